// ===== rtl/stsc_pkg.sv =====
// Shared constants and types for the slot table with circular search.
package stsc_pkg;

    // Default table geometry
    localparam int DEF_SLOTS       = 32;
    localparam int DEF_HANDLE_BITS = 16;

    // Port field widths
    localparam int FUNC_W   = 3;
    localparam int IDX_W    = 5;
    localparam int EH_W     = 16;
    localparam int STATUS_W = 3;

    // Operation codes
    localparam logic [FUNC_W-1:0] F_INS_FREE = 3'd0;
    localparam logic [FUNC_W-1:0] F_INS_AT   = 3'd1;
    localparam logic [FUNC_W-1:0] F_REMOVE   = 3'd2;
    localparam logic [FUNC_W-1:0] F_READ     = 3'd3;
    localparam logic [FUNC_W-1:0] F_NEXT     = 3'd4;
    localparam logic [FUNC_W-1:0] F_PREV     = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OCCUPIED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // Sequencer to scan unit controls
    typedef struct packed {
        logic load;   // take the start position
        logic step;   // advance one slot
        logic down;   // step toward lower slots
        logic want;   // occupancy value being searched for
    } scan_ctrl_t;

endpackage

// ===== rtl/stsc_handle_ram.sv =====
// Handle store: one write port, one registered read port.
module stsc_handle_ram #(
    parameter int DEPTH = stsc_pkg::DEF_SLOTS,
    parameter int WIDTH = stsc_pkg::DEF_HANDLE_BITS
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    import stsc_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/stsc_scan_unit.sv =====
// Circular scan unit: a wrapping slot pointer and one occupancy compare.
module stsc_scan_unit #(
    parameter int SLOTS = stsc_pkg::DEF_SLOTS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  stsc_pkg::scan_ctrl_t     ctrl,
    input  logic [$clog2(SLOTS)-1:0] start,
    input  logic [SLOTS-1:0]         occ,
    output logic [$clog2(SLOTS)-1:0] pos,
    output logic                     hit
);
    import stsc_pkg::*;

    localparam int               IW   = $clog2(SLOTS);
    localparam logic [IW-1:0]    LAST = IW'(SLOTS - 1);

    logic [IW-1:0] pos_reg;
    logic [IW-1:0] pos_next;

    always_comb
    begin
        pos_next = pos_reg;
        if (ctrl.load)
        begin
            pos_next = start;
        end
        else if (ctrl.step)
        begin
            if (ctrl.down)
            begin
                pos_next = (pos_reg == '0) ? LAST : pos_reg - IW'(1);
            end
            else
            begin
                pos_next = (pos_reg == LAST) ? '0 : pos_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;
    assign hit = (occ[pos_reg] == ctrl.want);

endmodule

// ===== rtl/slot_table_with_circular_search.sv =====
// Flow: read, remove, insert at slot, a full-table insert and a search of an empty table
// go from decode straight to finish; other inserts and searches pass through the scan
// state, where the pointer steps at most SLOTS - 1 slots, one slot per cycle.
// Throughput: one operation at a time; the next input transfer is taken the cycle after the
// result enters the output register, which waits while the output is stalled.
// Reset clears occupancy map and count at once; handles are not cleared, only read if occupied.
module slot_table_with_circular_search #(
    parameter int SLOTS       = stsc_pkg::DEF_SLOTS,
    parameter int HANDLE_BITS = stsc_pkg::DEF_HANDLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [stsc_pkg::FUNC_W-1:0]   func,
    input  logic [stsc_pkg::IDX_W-1:0]    slot_index,
    input  logic [stsc_pkg::EH_W-1:0]     entry_handle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [stsc_pkg::STATUS_W-1:0] status,
    output logic [stsc_pkg::IDX_W-1:0]    found_index,
    output logic [stsc_pkg::EH_W-1:0]     found_handle,
    output logic                          slot_occupied,
    output logic                          has_space,
    output logic                          all_empty
);
    import stsc_pkg::*;

    localparam int            IW   = $clog2(SLOTS);
    localparam int            CW   = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
    localparam logic [CW-1:0] FULL = CW'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    logic [FUNC_W-1:0]      func_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   in_range_reg;
    logic [HANDLE_BITS-1:0] hnd_reg;
    logic [SLOTS-1:0]       occ_reg;
    logic [CW-1:0]          count_reg;

    // pending result
    logic [STATUS_W-1:0]    res_status_reg;
    logic [IDX_W-1:0]       res_idx_reg;
    logic [EH_W-1:0]        res_handle_reg;
    logic                   res_occ_reg;
    logic                   use_rd_reg;

    // output register
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [IDX_W-1:0]       found_index_reg;
    logic [EH_W-1:0]        found_handle_reg;
    logic                   slot_occupied_reg;
    logic                   has_space_reg;
    logic                   all_empty_reg;

    logic [IW-1:0]          idx_i;
    logic                   occ_at_idx;
    logic                   in_range;
    scan_ctrl_t             scan_ctrl;
    logic [IW-1:0]          scan_start;
    logic [IW-1:0]          scan_pos;
    logic                   scan_hit;
    logic                   ram_wr_en;
    logic [IW-1:0]          ram_wr_addr;
    logic                   ram_rd_en;
    logic [IW-1:0]          ram_rd_addr;
    logic [HANDLE_BITS-1:0] ram_rd_data;

    assign in_range   = (32'(slot_index) < SLOTS);
    assign idx_i      = IW'(idx_reg);
    assign occ_at_idx = in_range_reg & occ_reg[idx_i];

    always_comb
    begin
        scan_ctrl.load = 1'b0;
        scan_ctrl.step = 1'b0;
        scan_ctrl.down = (func_reg == F_PREV);
        scan_ctrl.want = (func_reg != F_INS_FREE);
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_i;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = idx_i;

        // out-of-range start: next begins at slot 0, previous at the last slot
        if (func_reg == F_PREV)
        begin
            if (!in_range_reg)
            begin
                scan_start = LAST;
            end
            else
            begin
                scan_start = (idx_i == '0) ? LAST : idx_i - IW'(1);
            end
        end
        else if (func_reg == F_NEXT)
        begin
            if (!in_range_reg)
            begin
                scan_start = '0;
            end
            else
            begin
                scan_start = (idx_i == LAST) ? '0 : idx_i + IW'(1);
            end
        end
        else
        begin
            scan_start = '0;
        end

        unique case (state_reg)
            S_DECIDE:
            begin
                unique case (func_reg) inside
                    F_INS_FREE:
                    begin
                        scan_ctrl.load = (count_reg != FULL);
                    end
                    F_INS_AT:
                    begin
                        ram_wr_en = in_range_reg & ~occ_reg[idx_i];
                        ram_rd_en = occ_at_idx;
                    end
                    F_REMOVE, F_READ:
                    begin
                        ram_rd_en = occ_at_idx;
                    end
                    F_NEXT, F_PREV:
                    begin
                        scan_ctrl.load = (count_reg != '0);
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                ram_wr_addr = scan_pos;
                ram_rd_addr = scan_pos;
                if (scan_hit)
                begin
                    ram_wr_en = (func_reg == F_INS_FREE);
                    ram_rd_en = (func_reg != F_INS_FREE);
                end
                else
                begin
                    scan_ctrl.step = 1'b1;
                end
            end
            S_IDLE, S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    stsc_scan_unit #(
        .SLOTS (SLOTS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .start (scan_start),
        .occ   (occ_reg),
        .pos   (scan_pos),
        .hit   (scan_hit)
    );

    stsc_handle_ram #(
        .DEPTH (SLOTS),
        .WIDTH (HANDLE_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (hnd_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            func_reg          <= '0;
            idx_reg           <= '0;
            in_range_reg      <= 1'b0;
            hnd_reg           <= '0;
            occ_reg           <= '0;
            count_reg         <= '0;
            res_status_reg    <= '0;
            res_idx_reg       <= '0;
            res_handle_reg    <= '0;
            res_occ_reg       <= 1'b0;
            use_rd_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            status_reg        <= '0;
            found_index_reg   <= '0;
            found_handle_reg  <= '0;
            slot_occupied_reg <= 1'b0;
            has_space_reg     <= 1'b0;
            all_empty_reg     <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FINISH && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg     <= func;
                        idx_reg      <= slot_index;
                        in_range_reg <= in_range;
                        hnd_reg      <= HANDLE_BITS'(entry_handle);
                        state_reg    <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    res_idx_reg    <= idx_reg;
                    res_handle_reg <= '0;
                    res_occ_reg    <= 1'b0;
                    use_rd_reg     <= 1'b0;
                    res_status_reg <= ST_NOTFOUND;
                    state_reg      <= S_FINISH;
                    unique case (func_reg) inside
                        F_INS_FREE:
                        begin
                            if (count_reg == FULL)
                            begin
                                res_status_reg <= ST_FULL;
                                res_idx_reg    <= '0;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        F_INS_AT:
                        begin
                            res_status_reg <= ST_OCCUPIED;
                            if (in_range_reg && !occ_reg[idx_i])
                            begin
                                occ_reg[idx_i] <= 1'b1;
                                count_reg      <= count_reg + CW'(1);
                                res_status_reg <= ST_OK;
                                res_handle_reg <= EH_W'(hnd_reg);
                                res_occ_reg    <= 1'b1;
                            end
                            else if (occ_at_idx)
                            begin
                                use_rd_reg  <= 1'b1;
                                res_occ_reg <= 1'b1;
                            end
                        end
                        F_REMOVE:
                        begin
                            if (occ_at_idx)
                            begin
                                occ_reg[idx_i] <= 1'b0;
                                count_reg      <= count_reg - CW'(1);
                                use_rd_reg     <= 1'b1;
                                res_status_reg <= ST_OK;
                            end
                            else
                            begin
                                res_status_reg <= ST_EMPTY;
                            end
                        end
                        F_READ:
                        begin
                            res_status_reg <= in_range_reg ? ST_OK : ST_EMPTY;
                            if (occ_at_idx)
                            begin
                                use_rd_reg  <= 1'b1;
                                res_occ_reg <= 1'b1;
                            end
                        end
                        F_NEXT, F_PREV:
                        begin
                            res_idx_reg <= '0;
                            if (count_reg != '0)
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_idx_reg <= '0;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        res_status_reg <= ST_OK;
                        res_idx_reg    <= IDX_W'(scan_pos);
                        res_occ_reg    <= 1'b1;
                        if (func_reg == F_INS_FREE)
                        begin
                            occ_reg[scan_pos] <= 1'b1;
                            count_reg         <= count_reg + CW'(1);
                            res_handle_reg    <= EH_W'(hnd_reg);
                        end
                        else
                        begin
                            use_rd_reg <= 1'b1;
                        end
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        status_reg        <= res_status_reg;
                        found_index_reg   <= res_idx_reg;
                        found_handle_reg  <= use_rd_reg ? EH_W'(ram_rd_data) : res_handle_reg;
                        slot_occupied_reg <= res_occ_reg;
                        has_space_reg     <= (count_reg != FULL);
                        all_empty_reg     <= (count_reg == '0);
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found_index   = found_index_reg;
    assign found_handle  = found_handle_reg;
    assign slot_occupied = slot_occupied_reg;
    assign has_space     = has_space_reg;
    assign all_empty     = all_empty_reg;

    // occupancy count tracks the map
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(occ_reg)))
        else $error("occupancy count out of step with map");

    // a handle is only written into a free slot
    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> !occ_reg[ram_wr_addr])
        else $error("handle write to occupied slot");

    // a search scan never runs on an empty table
    a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && func_reg != F_INS_FREE) |-> count_reg != '0)
        else $error("search scan on empty table");

    // a free-slot scan never runs on a full table
    a_insert_notfull: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && func_reg == F_INS_FREE) |-> count_reg != FULL)
        else $error("free-slot scan on full table");

    // an input transfer starts decoding next cycle
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_DECIDE)
        else $error("input transfer not decoded");

endmodule
